### hdl/sbct_pkg.sv
// Package for the swept box collision test: payload structs, time constants,
// register indexes and pipeline sizes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbct_pkg;

   // Coordinates and displacements are signed Q16.16; the fraction cancels in every ratio.
   localparam int CoordW       = 32;
   localparam int GapW         = CoordW + 1;
   localparam int TimeFracBits = 16;
   // Signed time range covers +/- 4.0 (the infinity stand-in)
   localparam int TimeW        = TimeFracBits + 4;
   localparam int EntryTimeW   = TimeFracBits + 1;
   // Quotient bits produced by the divider: values below 8.0
   localparam int QuotW        = TimeFracBits + 3;
   // Divider pipeline depth: setup stage, one stage per quotient bit, finish stage
   localparam int DivLatency   = QuotW + 2;

   localparam logic signed [TimeW-1:0] TOne = TimeW'(1) <<< TimeFracBits;
   localparam logic signed [TimeW-1:0] TSat = TimeW'(2) <<< TimeFracBits;
   localparam logic signed [TimeW-1:0] TInf = TimeW'(4) <<< TimeFracBits;

   localparam int QueueDepthDefault = 4;
   localparam int RspDepth          = 2;
   localparam int CsrAddrW          = 4;
   localparam int CsrDataW          = 32;

   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   typedef enum logic [1:0] {
      REG_DISP_X = 2'd0,
      REG_DISP_Y = 2'd1,
      REG_DISP_Z = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [CoordW-1:0] moving_min_x;
      logic signed [CoordW-1:0] moving_min_y;
      logic signed [CoordW-1:0] moving_min_z;
      logic signed [CoordW-1:0] moving_max_x;
      logic signed [CoordW-1:0] moving_max_y;
      logic signed [CoordW-1:0] moving_max_z;
      logic signed [CoordW-1:0] obstacle_min_x;
      logic signed [CoordW-1:0] obstacle_min_y;
      logic signed [CoordW-1:0] obstacle_min_z;
      logic signed [CoordW-1:0] obstacle_max_x;
      logic signed [CoordW-1:0] obstacle_max_y;
      logic signed [CoordW-1:0] obstacle_max_z;
   } req_type;

   typedef struct packed {
      logic                  broad_overlap;
      logic                  hit;
      logic [EntryTimeW-1:0] entry_time;
      logic [1:0]            normal_axis;
      logic                  normal_negative;
   } rsp_type;

   // Displacement facts the back end needs, kept per axis
   typedef struct packed {
      logic [2:0]              dzero;
      logic [2:0]              dpos;
      logic [2:0][CoordW-1:0]  dabs;
   } disp_info_type;

   // Entry and exit gaps, already sign-folded so the divisor is |d|
   typedef struct packed {
      logic [2:0][GapW-1:0] g_in;
      logic [2:0][GapW-1:0] g_out;
   } gaps_type;

endpackage

`default_nettype wire

### hdl/swept_box_collision_test.sv
// Swept box collision test, top level: front end, back end and result queue.
// Depends on sbct_pkg, sbct_front, sbct_back, sbct_fifo.
//
// Each request carries a moving box and an obstacle box; the moving box travels
// by the displacement held in the three disp registers (byte addresses 0, 4, 8).
// One result per request, in order. A new request is taken every cycle while
// results are popped; a request passes through the gap queue, the broadphase
// stage, the dividers (one quotient bit per pipeline stage) and the reduction
// stage into the result queue. The user must write the registers only while
// no request is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module swept_box_collision_test
   import sbct_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  req_type             req_data,
   output logic                req_full,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_type             rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   disp_info_type disp_info;
   gaps_type      gap_data;
   logic          gap_pop, gap_empty;
   logic          res_push, res_full;
   rsp_type       res_data;
   logic [$bits(rsp_type)-1:0] res_dout;

   sbct_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .disp_info   (disp_info),
      .gap_pop     (gap_pop),
      .gap_data    (gap_data),
      .gap_empty   (gap_empty)
   );

   sbct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .disp_info (disp_info),
      .gap_data  (gap_data),
      .gap_empty (gap_empty),
      .gap_pop   (gap_pop),
      .rsp_push  (res_push),
      .rsp_data  (res_data),
      .rsp_full  (res_full)
   );

   // result queue parts the back end from the consumer
   sbct_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RspDepth)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (res_dout),
      .empty (rsp_empty)
   );

   assign rsp_data = res_dout;

endmodule

`default_nettype wire

### hdl/sbct_fifo.sv
// Small synchronous queue built from flip-flops.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sbct_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

### hdl/sbct_front.sv
// Front end: displacement registers on the APB-style port, gap forming for each
// request and the queue toward the back end. Depends on sbct_pkg, sbct_fifo.
`timescale 1ns / 1ps
`default_nettype none

module sbct_front
   import sbct_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   // request side
   input  logic                req_push,
   input  req_type             req_data,
   output logic                req_full,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready,
   // toward the back end
   output disp_info_type       disp_info,
   input  logic                gap_pop,
   output gaps_type            gap_data,
   output logic                gap_empty
);

   logic [2:0][CoordW-1:0] disp_ff, disp_in;
   logic [2:0][CoordW-1:0] dabs_ff, dabs_in;
   reg_index_type          reg_index;
   logic                   csr_write;
   logic [CoordW-1:0]      wdata_abs;
   logic [$bits(gaps_type)-1:0] gap_dout;
   gaps_type               gaps;
   logic signed [CoordW-1:0] amin [3];
   logic signed [CoordW-1:0] amax [3];
   logic signed [CoordW-1:0] bmin [3];
   logic signed [CoordW-1:0] bmax [3];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign wdata_abs  = csr_pwdata[CsrDataW-1] ? (~csr_pwdata + 1'b1) : csr_pwdata;

   // register writes; the magnitude is kept beside each displacement
   always_comb begin
      disp_in = disp_ff;
      dabs_in = dabs_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_DISP_X: begin
               disp_in[0] = csr_pwdata;
               dabs_in[0] = wdata_abs;
            end
            REG_DISP_Y: begin
               disp_in[1] = csr_pwdata;
               dabs_in[1] = wdata_abs;
            end
            REG_DISP_Z: begin
               disp_in[2] = csr_pwdata;
               dabs_in[2] = wdata_abs;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff <= '0;
         dabs_ff <= '0;
      end else begin
         disp_ff <= disp_in;
         dabs_ff <= dabs_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_index)
         REG_DISP_X: csr_prdata = disp_ff[0];
         REG_DISP_Y: csr_prdata = disp_ff[1];
         REG_DISP_Z: csr_prdata = disp_ff[2];
         default:    csr_prdata = '0;
      endcase
   end

   // displacement classification per axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         disp_info.dzero[i] = (disp_ff[i] == '0);
         disp_info.dpos[i]  = !disp_ff[i][CoordW-1] && (disp_ff[i] != '0);
         disp_info.dabs[i]  = dabs_ff[i];
      end
   end

   assign amin[0] = req_data.moving_min_x;
   assign amin[1] = req_data.moving_min_y;
   assign amin[2] = req_data.moving_min_z;
   assign amax[0] = req_data.moving_max_x;
   assign amax[1] = req_data.moving_max_y;
   assign amax[2] = req_data.moving_max_z;
   assign bmin[0] = req_data.obstacle_min_x;
   assign bmin[1] = req_data.obstacle_min_y;
   assign bmin[2] = req_data.obstacle_min_z;
   assign bmax[0] = req_data.obstacle_max_x;
   assign bmax[1] = req_data.obstacle_max_y;
   assign bmax[2] = req_data.obstacle_max_z;

   // gaps with the sign of d folded in, so that each divides by |d|
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (disp_info.dpos[i]) begin
            gaps.g_in[i]  = GapW'($signed(bmin[i])) - GapW'($signed(amax[i]));
            gaps.g_out[i] = GapW'($signed(bmax[i])) - GapW'($signed(amin[i]));
         end else begin
            gaps.g_in[i]  = GapW'($signed(amin[i])) - GapW'($signed(bmax[i]));
            gaps.g_out[i] = GapW'($signed(amax[i])) - GapW'($signed(bmin[i]));
         end
      end
   end

   sbct_fifo #(
      .WIDTH ($bits(gaps_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_gap_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (gaps),
      .full  (req_full),
      .pop   (gap_pop),
      .dout  (gap_dout),
      .empty (gap_empty)
   );

   assign gap_data = gap_dout;

endmodule

`default_nettype wire

### hdl/sbct_divider.sv
// Pipelined restoring divider: floor(gap * 2^TimeFracBits / |d|), saturated to
// +/- 2.0, one quotient bit per stage. Depends on sbct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbct_divider
   import sbct_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  logic [GapW-1:0]         mag,
   input  logic                    neg,
   input  logic [CoordW-1:0]       dabs,
   output logic signed [TimeW-1:0] time_out
);

   logic [CoordW-1:0] r_ff    [QuotW+1];
   logic [CoordW-1:0] r_in    [QuotW+1];
   logic [QuotW-1:0]  q_ff    [QuotW+1];
   logic [QuotW-1:0]  q_in    [QuotW+1];
   logic [GapW-1:0]   mag_ff  [QuotW+1];
   logic [GapW-1:0]   mag_in  [QuotW+1];
   logic              neg_ff  [QuotW+1];
   logic              neg_in  [QuotW+1];
   logic              ovf_ff  [QuotW+1];
   logic              ovf_in  [QuotW+1];
   logic signed [TimeW-1:0] time_ff, time_in;
   logic [TimeW-1:0]  q_ext;
   logic              q_sat, r_nz;

   // setup: a quotient of 8.0 or more only saturates
   always_comb begin
      ovf_in[0] = (mag >> 3) >= {1'b0, dabs};
      r_in[0]   = CoordW'(mag >> 3);
      q_in[0]   = '0;
      mag_in[0] = mag;
      neg_in[0] = neg;
   end

   // one quotient bit per stage
   for (genvar s = 1; s <= QuotW; s++) begin : g_stage
      localparam int BitPos = QuotW - s;
      logic              in_bit;
      logic [CoordW:0]   trial;
      logic              ge;
      if (BitPos >= TimeFracBits) begin : g_data_bit
         assign in_bit = mag_ff[s-1][BitPos - TimeFracBits];
      end else begin : g_zero_bit
         assign in_bit = 1'b0;
      end
      assign trial     = {r_ff[s-1], in_bit};
      assign ge        = trial >= {1'b0, dabs};
      assign r_in[s]   = ge ? CoordW'(trial - {1'b0, dabs}) : trial[CoordW-1:0];
      assign q_in[s]   = {q_ff[s-1][QuotW-2:0], ge};
      assign mag_in[s] = mag_ff[s-1];
      assign neg_in[s] = neg_ff[s-1];
      assign ovf_in[s] = ovf_ff[s-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= QuotW; s++) begin
            r_ff[s]   <= r_in[s];
            q_ff[s]   <= q_in[s];
            mag_ff[s] <= mag_in[s];
            neg_ff[s] <= neg_in[s];
            ovf_ff[s] <= ovf_in[s];
         end
      end
   end

   // finish: saturate, then floor toward minus infinity for negative gaps
   assign q_ext = {1'b0, q_ff[QuotW]};
   assign q_sat = ovf_ff[QuotW] || ($signed(q_ext) >= TSat);
   assign r_nz  = (r_ff[QuotW] != '0);

   always_comb begin
      if (!neg_ff[QuotW]) begin
         time_in = q_sat ? TSat : $signed(q_ext);
      end else if (q_sat) begin
         time_in = -TSat;
      end else begin
         time_in = r_nz ? $signed(~q_ext) : -$signed(q_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         time_ff <= time_in;
      end
   end

   assign time_out = time_ff;

endmodule

`default_nettype wire

### hdl/sbct_back.sv
// Back end: broadphase test, six axis-time dividers, entry/exit reduction and
// result forming. Depends on sbct_pkg, sbct_divider.
`timescale 1ns / 1ps
`default_nettype none

module sbct_back
   import sbct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  disp_info_type disp_info,
   input  gaps_type      gap_data,
   input  logic          gap_empty,
   output logic          gap_pop,
   output logic          rsp_push,
   output rsp_type       rsp_data,
   input  logic          rsp_full
);

   logic adv;

   // stage 1: magnitudes, signs and broadphase
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_broad_ff, s1_broad_in;
   logic [2:0][GapW-1:0] s1_in_mag_ff, s1_in_mag_in, s1_out_mag_ff, s1_out_mag_in;
   logic [2:0]           s1_in_neg_ff, s1_in_neg_in, s1_out_neg_ff, s1_out_neg_in;

   // tags riding alongside the dividers
   logic                 side_valid_ff [DivLatency];
   logic                 side_broad_ff [DivLatency];

   logic signed [TimeW-1:0] t_in  [3];
   logic signed [TimeW-1:0] t_out [3];

   // reduction stage
   logic                    c1_valid_ff, c1_valid_in;
   logic                    c1_broad_ff, c1_broad_in;
   logic                    c1_late_ff, c1_late_in;
   logic [1:0]              c1_axis_ff, c1_axis_in;
   logic signed [TimeW-1:0] c1_best_ff, c1_best_in;
   logic signed [TimeW-1:0] c1_exit_ff, c1_exit_in;
   logic signed [TimeW-1:0] ent [3];
   logic signed [TimeW-1:0] ext [3];
   logic                    hit;

   // the whole back end moves unless a finished result cannot leave
   assign adv      = !(c1_valid_ff && rsp_full);
   assign gap_pop  = adv && !gap_empty;
   assign rsp_push = c1_valid_ff && adv;

   always_comb begin
      s1_valid_in = !gap_empty;
      s1_broad_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         s1_in_neg_in[i]  = gap_data.g_in[i][GapW-1];
         s1_out_neg_in[i] = gap_data.g_out[i][GapW-1];
         s1_in_mag_in[i]  = s1_in_neg_in[i] ? (~gap_data.g_in[i] + 1'b1) : gap_data.g_in[i];
         s1_out_mag_in[i] = s1_out_neg_in[i] ? (~gap_data.g_out[i] + 1'b1)
                                             : gap_data.g_out[i];
         // swept interval overlaps: exit gap not negative, entry gap within |d|
         if (s1_out_neg_in[i] ||
             ($signed(gap_data.g_in[i]) > $signed({1'b0, disp_info.dabs[i]}))) begin
            s1_broad_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_broad_ff   <= s1_broad_in;
         s1_in_mag_ff  <= s1_in_mag_in;
         s1_out_mag_ff <= s1_out_mag_in;
         s1_in_neg_ff  <= s1_in_neg_in;
         s1_out_neg_ff <= s1_out_neg_in;
      end
   end

   // entry and exit dividers for each axis
   for (genvar i = 0; i < 3; i++) begin : g_axis
      sbct_divider u_div_in (
         .clock    (clock),
         .en       (adv),
         .mag      (s1_in_mag_ff[i]),
         .neg      (s1_in_neg_ff[i]),
         .dabs     (disp_info.dabs[i]),
         .time_out (t_in[i])
      );
      sbct_divider u_div_out (
         .clock    (clock),
         .en       (adv),
         .mag      (s1_out_mag_ff[i]),
         .neg      (s1_out_neg_ff[i]),
         .dabs     (disp_info.dabs[i]),
         .time_out (t_out[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DivLatency; k++) begin
            side_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         side_valid_ff[0] <= s1_valid_ff;
         for (int k = 1; k < DivLatency; k++) begin
            side_valid_ff[k] <= side_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_broad_ff[0] <= s1_broad_ff;
         for (int k = 1; k < DivLatency; k++) begin
            side_broad_ff[k] <= side_broad_ff[k-1];
         end
      end
   end

   // latest entry (x wins ties, then y), earliest exit, late entry check
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ent[i] = disp_info.dzero[i] ? -TInf : t_in[i];
         ext[i] = disp_info.dzero[i] ? TInf : t_out[i];
      end
      c1_valid_in = side_valid_ff[DivLatency-1];
      c1_broad_in = side_broad_ff[DivLatency-1];
      c1_best_in  = ent[0];
      c1_axis_in  = AxisX;
      if (ent[1] > c1_best_in) begin
         c1_best_in = ent[1];
         c1_axis_in = AxisY;
      end
      if (ent[2] > c1_best_in) begin
         c1_best_in = ent[2];
         c1_axis_in = AxisZ;
      end
      c1_exit_in = ext[0];
      if (ext[1] < c1_exit_in) begin
         c1_exit_in = ext[1];
      end
      if (ext[2] < c1_exit_in) begin
         c1_exit_in = ext[2];
      end
      c1_late_in = (ent[0] > TOne) || (ent[1] > TOne) || (ent[2] > TOne);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else if (adv) begin
         c1_valid_ff <= c1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_broad_ff <= c1_broad_in;
         c1_late_ff  <= c1_late_in;
         c1_axis_ff  <= c1_axis_in;
         c1_best_ff  <= c1_best_in;
         c1_exit_ff  <= c1_exit_in;
      end
   end

   // result forming
   assign hit = c1_broad_ff && !c1_late_ff && (c1_best_ff >= 0) && (c1_best_ff <= c1_exit_ff);

   always_comb begin
      rsp_data.broad_overlap = c1_broad_ff;
      rsp_data.hit           = hit;
      if (hit) begin
         rsp_data.entry_time      = c1_best_ff[EntryTimeW-1:0];
         rsp_data.normal_axis     = c1_axis_ff;
         rsp_data.normal_negative = disp_info.dpos[c1_axis_ff];
      end else begin
         rsp_data.entry_time      = TOne[EntryTimeW-1:0];
         rsp_data.normal_axis     = AxisX;
         rsp_data.normal_negative = 1'b0;
      end
   end

endmodule

`default_nettype wire

### hdl/sbct_checker.sv
// Port-level checks for the swept box collision test, bound to the top level.
// Depends on sbct_pkg and swept_box_collision_test.
`timescale 1ns / 1ps
`default_nettype none

module sbct_checker
   import sbct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data,
   input logic    csr_pready
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a hit lies inside the broadphase and within the frame
   a_hit_in_frame: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.hit) |->
         (rsp_data.broad_overlap && (rsp_data.entry_time <= TOne[EntryTimeW-1:0]) &&
          (rsp_data.normal_axis != 2'd3)))
      else $error("hit result out of range");

   // a miss reports the neutral contact fields
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.hit) |->
         ((rsp_data.entry_time == TOne[EntryTimeW-1:0]) &&
          (rsp_data.normal_axis == AxisX) && !rsp_data.normal_negative))
      else $error("miss result carries contact fields");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while waiting");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind swept_box_collision_test sbct_checker u_sbct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_full   (req_full),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

`default_nettype wire

### dv/swept_box_collision_test_tb.sv
// Testbench for the swept box collision test: random and directed box pairs
// against several displacement settings, checked by an in-bench predictor.
// Depends on sbct_pkg and swept_box_collision_test.
`timescale 1ns / 1ps

module swept_box_collision_test_tb;
   import sbct_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 40;

   logic                clock;
   logic                reset;
   logic                req_push;
   req_type             req_data;
   logic                req_full;
   logic                rsp_empty;
   logic                rsp_pop;
   rsp_type             rsp_data;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   swept_box_collision_test uut (.*);

   // displacement copy used by the predictor
   logic signed [31:0] disp_model [3];
   req_type pending_boxes [$];
   rsp_type expected_contacts [$];
   int  send_idle_pct, recv_idle_pct;
   int  mismatches;
   int  watchdog;
   bit  timed_out;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // queue helpers
   function automatic void append_box(req_type b);
      pending_boxes = {pending_boxes, b};
   endfunction

   function automatic void append_contact(rsp_type r);
      expected_contacts = {expected_contacts, r};
   endfunction

   // floor(gap * 2^16 / d), saturated to +/- 2.0
   function automatic longint axis_ratio(longint gap, longint d);
      longint mag, q, r, t;
      if (d < 0) begin
         gap = -gap;
         d = -d;
      end
      mag = (gap < 0) ? -gap : gap;
      mag = mag <<< 16;
      q = mag / d;
      r = mag % d;
      if (q > 4 * 65536) q = 4 * 65536;
      t = (gap < 0) ? (-q - (r != 0)) : q;
      if (t > 2 * 65536) t = 2 * 65536;
      if (t < -2 * 65536) t = -2 * 65536;
      return t;
   endfunction

   function automatic rsp_type predict_contact(req_type b);
      rsp_type r;
      longint amin[3], amax[3], bmin[3], bmax[3], ent[3], ext[3];
      longint d, smin, smax, gin, gout, best, first_exit;
      bit broad, late, hit;
      int axis;
      amin = '{b.moving_min_x, b.moving_min_y, b.moving_min_z};
      amax = '{b.moving_max_x, b.moving_max_y, b.moving_max_z};
      bmin = '{b.obstacle_min_x, b.obstacle_min_y, b.obstacle_min_z};
      bmax = '{b.obstacle_max_x, b.obstacle_max_y, b.obstacle_max_z};
      broad = 1;
      late = 0;
      for (int i = 0; i < 3; i++) begin
         d = disp_model[i];
         smin = (d > 0) ? amin[i] : amin[i] + d;
         smax = (d > 0) ? amax[i] + d : amax[i];
         if (!(smin <= bmax[i] && smax >= bmin[i])) broad = 0;
         gin  = (d > 0) ? bmin[i] - amax[i] : bmax[i] - amin[i];
         gout = (d > 0) ? bmax[i] - amin[i] : bmin[i] - amax[i];
         if (d == 0) begin
            ent[i] = -4 * 65536;
            ext[i] = 4 * 65536;
         end else begin
            ent[i] = axis_ratio(gin, d);
            ext[i] = axis_ratio(gout, d);
         end
         if (ent[i] > 65536) late = 1;
      end
      best = ent[0];
      axis = 0;
      if (ent[1] > best) begin best = ent[1]; axis = 1; end
      if (ent[2] > best) begin best = ent[2]; axis = 2; end
      first_exit = ext[0];
      if (ext[1] < first_exit) first_exit = ext[1];
      if (ext[2] < first_exit) first_exit = ext[2];
      hit = broad && !late && best >= 0 && best <= first_exit;
      r.broad_overlap = broad;
      r.hit = hit;
      if (hit) begin
         r.entry_time = best[16:0];
         r.normal_axis = axis[1:0];
         r.normal_negative = disp_model[axis] > 0;
      end else begin
         r.entry_time = 17'h10000;
         r.normal_axis = AxisX;
         r.normal_negative = 0;
      end
      return r;
   endfunction

   // driver: pushes pending boxes, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 0;
      end else begin
         if (req_push && !req_full) begin
            append_contact(predict_contact(req_data));
            void'(pending_boxes.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (pending_boxes.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_push <= 1;
               req_data <= pending_boxes[0];
            end else begin
               req_push <= 0;
            end
         end
      end
   end

   // monitor: pops results and compares against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 0;
         watchdog <= 0;
      end else begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) watchdog <= 0;
         else watchdog <= watchdog + 1;
         if (rsp_pop && !rsp_empty) begin
            if (expected_contacts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected request result %p", rsp_data);
            end else begin
               if (rsp_data !== expected_contacts[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected %p got %p",
                              expected_contacts[0], rsp_data);
               end
               void'(expected_contacts.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_disp(reg_index_type idx, logic signed [31:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= CsrAddrW'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      disp_model[idx] = value;
   endtask

   task automatic set_disp(logic signed [31:0] dx, logic signed [31:0] dy,
                           logic signed [31:0] dz);
      write_disp(REG_DISP_X, dx);
      write_disp(REG_DISP_Y, dy);
      write_disp(REG_DISP_Z, dz);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $urandom();
         default: return $signed($urandom_range(40 * 65536)) - 20 * 65536;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_disp();
      case ($urandom_range(7))
         0: return 0;
         1: return 32'sh7FFFFFFF;
         2: return 32'sh80000000;
         3: return $urandom();
         4: return $signed($urandom_range(7)) - 3;
         default: return $signed($urandom_range(24 * 65536)) - 12 * 65536;
      endcase
   endfunction

   // well-formed boxes near each other, mostly; raw noise otherwise
   function automatic req_type rand_boxes();
      req_type b;
      logic signed [31:0] sz;
      if ($urandom_range(9) == 0) begin
         b = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         return b;
      end
      b = '0;
      for (int a = 0; a < 3; a++) begin
         logic signed [31:0] mn, mx, on, ox;
         mn = rand_coord();
         sz = $urandom_range(4 * 65536);
         mx = ($urandom_range(19) == 0) ? mn - sz : mn + sz;
         on = mn + $signed($urandom_range(16 * 65536)) - 8 * 65536;
         ox = on + $urandom_range(4 * 65536);
         case (a)
            0: begin b.moving_min_x = mn; b.moving_max_x = mx;
                     b.obstacle_min_x = on; b.obstacle_max_x = ox; end
            1: begin b.moving_min_y = mn; b.moving_max_y = mx;
                     b.obstacle_min_y = on; b.obstacle_max_y = ox; end
            default: begin b.moving_min_z = mn; b.moving_max_z = mx;
                     b.obstacle_min_z = on; b.obstacle_max_z = ox; end
         endcase
      end
      return b;
   endfunction

   task automatic drain();
      while (pending_boxes.size() != 0 || expected_contacts.size() != 0 || req_push) begin
         @(posedge clock);
         if (watchdog >= WatchdogLimit) begin
            timed_out = 1;
            return;
         end
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      req_type b;
      timed_out = 0;
      mismatches = 0;
      reset = 1;
      req_push = 0;
      req_data = '0;
      rsp_pop = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (int i = 0; i < 3; i++) disp_model[i] = 0;
      send_idle_pct = 21;
      recv_idle_pct = 65;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: all-zero displacement, touching and separated boxes
      b = '0;
      append_box(b);
      b.obstacle_min_x = 5 << 16;
      b.obstacle_max_x = 6 << 16;
      append_box(b);
      drain();

      // directed: motion toward obstacle on x and y with ties, then extreme and negative displacements
      set_disp(4 << 16, 4 << 16, 0);
      b = '0;
      b.moving_max_x = 1 << 16; b.moving_max_y = 1 << 16; b.moving_max_z = 1 << 16;
      b.obstacle_min_x = 3 << 16; b.obstacle_max_x = 4 << 16;
      b.obstacle_min_y = 3 << 16; b.obstacle_max_y = 4 << 16;
      b.obstacle_max_z = 1 << 16;
      append_box(b);
      b.obstacle_min_y = 2 << 16;
      append_box(b);
      b.obstacle_max_z = -1;
      b.obstacle_min_z = -(1 << 16);
      append_box(b);
      b = '0;
      b.moving_min_x = 32'sh80000000; b.moving_max_x = 32'sh7FFFFFFF;
      b.obstacle_min_x = 32'sh7FFFFFFF; b.obstacle_max_x = 32'sh80000000;
      append_box(b);
      drain();
      set_disp(32'sh80000000, 32'sh7FFFFFFF, -(3 << 16));
      for (int i = 0; i < 12; i++) append_box(rand_boxes());
      drain();

      // random phases across displacement settings and idle mixes
      for (int phase = 0; phase < 12 && !timed_out; phase++) begin
         if (phase == 4) begin send_idle_pct = 65; recv_idle_pct = 21; end
         if (phase == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
         set_disp(rand_disp(), rand_disp(), rand_disp());
         for (int i = 0; i < 90; i++) append_box(rand_boxes());
         drain();
      end

      if (timed_out) begin
         $display("SCOREBOARD MISMATCH");
      end else if (mismatches == 0 && expected_contacts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/sbct_pkg.sv
hdl/sbct_fifo.sv
hdl/sbct_front.sv
hdl/sbct_divider.sv
hdl/sbct_back.sv
hdl/swept_box_collision_test.sv
hdl/sbct_checker.sv
dv/swept_box_collision_test_tb.sv
